// ----- rtl/trimmed_mean_adc_filter_top_assert.svh -----
// ----------------------------------------------------------------------------
// Trimmed-mean ADC filter assertion macros
// Concurrent assertion wrappers shared by the filter RTL.
// ----------------------------------------------------------------------------
`ifndef TRIMMED_MEAN_ADC_FILTER_TOP_ASSERT_SVH
`define TRIMMED_MEAN_ADC_FILTER_TOP_ASSERT_SVH

// Clocked property, switched off while reset is held
`define TMAF_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked property checked at every edge, reset included
`define TMAF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/tmaf_pkg.sv -----
// ----------------------------------------------------------------------------
// Trimmed-mean ADC filter package
// Widths, constants and types shared by the filter and its interfaces.
// ----------------------------------------------------------------------------
package tmaf_pkg;

    localparam int SAMPLE_W = 12;
    localparam int SUM_W    = 16;
    localparam int COUNT_W  = 4;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [SUM_W-1:0]    t_sum;
    typedef logic [COUNT_W-1:0]  t_count;

    // Rail codes: both are rejected
    localparam t_sample RAIL_LOW  = t_sample'(0);
    localparam t_sample RAIL_HIGH = t_sample'(4095);

    // Count value on the tenth sample of a window
    localparam t_count WINDOW_LAST = t_count'(9);

    // Divide-by-eight of the middle eight samples
    localparam int TRIM_SHIFT = 3;

endpackage

// ----- rtl/tmaf_stream_if.sv -----
// ----------------------------------------------------------------------------
// Trimmed-mean ADC filter stream interfaces
// Valid/ready channels for raw samples in and averages out.
// ----------------------------------------------------------------------------
interface tmaf_sample_if
    import tmaf_pkg::*;
;
    logic    valid;
    logic    ready;
    t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface tmaf_average_if
    import tmaf_pkg::*;
;
    logic    valid;
    logic    ready;
    t_sample average;

    modport source (output valid, output average, input ready);
    modport sink   (input valid, input average, output ready);
endinterface

// ----- rtl/trimmed_mean_adc_filter_top.sv -----
// The average is registered and valid in the cycle after the tenth non-rail sample is taken.
// Throughput: one sample per cycle while input ready is high; the window update is a combinational compare/add.
// Input ready falls only while a result is held and the sink stalls (output register).
// Reset (synchronous, active low) empties the window and drops the output valid.
// ----------------------------------------------------------------------------
// Trimmed-mean ADC filter
// Sums ten non-rail samples, drops the largest and smallest, outputs the
// mean of the middle eight.
// ----------------------------------------------------------------------------
`include "trimmed_mean_adc_filter_top_assert.svh"

module trimmed_mean_adc_filter_top
    import tmaf_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    tmaf_sample_if.sink    i_sample,
    tmaf_average_if.source o_average
);

    // Window state
    t_count  r_count, n_count;
    t_sum    r_sum, n_sum;
    t_sample r_max, n_max;
    t_sample r_min, n_min;
    logic    r_empty, n_empty;

    // Output register
    logic    r_out_valid, n_out_valid;
    t_sample r_average;

    logic    w_accept;
    logic    w_rail;
    logic    w_take;
    logic    w_last;
    logic    w_result;
    t_sample w_max_upd;
    t_sample w_min_upd;
    t_sum    w_sum_upd;
    t_sum    w_trimmed;

    // Handshake: take a sample whenever the output slot is free or draining
    assign i_sample.ready = !r_out_valid || o_average.ready;
    assign w_accept       = i_sample.valid && i_sample.ready;
    assign w_rail         = (i_sample.sample == RAIL_LOW) || (i_sample.sample == RAIL_HIGH);
    assign w_take         = w_accept && !w_rail;
    assign w_last         = (r_count == WINDOW_LAST);
    assign w_result       = w_take && w_last;

    // Max/min update, first sample of a window seeds both
    always_comb begin
        w_max_upd = r_max;
        w_min_upd = r_min;
        if (r_empty) begin
            w_max_upd = i_sample.sample;
            w_min_upd = i_sample.sample;
        end else if (i_sample.sample > r_max) begin
            w_max_upd = i_sample.sample;
        end else if (i_sample.sample < r_min) begin
            w_min_upd = i_sample.sample;
        end
    end

    // Running sum and trimmed total
    assign w_sum_upd = r_sum + t_sum'(i_sample.sample);
    assign w_trimmed = w_sum_upd - t_sum'(w_min_upd) - t_sum'(w_max_upd);

    // Next window state
    always_comb begin
        n_count = r_count;
        n_sum   = r_sum;
        n_max   = r_max;
        n_min   = r_min;
        n_empty = r_empty;
        if (w_result) begin
            n_count = '0;
            n_sum   = '0;
            n_max   = '0;
            n_min   = '0;
            n_empty = 1'b1;
        end else if (w_take) begin
            n_count = r_count + t_count'(1);
            n_sum   = w_sum_upd;
            n_max   = w_max_upd;
            n_min   = w_min_upd;
            n_empty = 1'b0;
        end
    end

    // Output valid: set on a window end, cleared once the transaction completes
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_result) begin
            n_out_valid = 1'b1;
        end else if (o_average.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_sum       <= '0;
            r_max       <= '0;
            r_min       <= '0;
            r_empty     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_max       <= n_max;
            r_min       <= n_min;
            r_empty     <= n_empty;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_result) begin
            r_average <= w_trimmed[TRIM_SHIFT +: SAMPLE_W];
        end
    end

    assign o_average.valid   = r_out_valid;
    assign o_average.average = r_average;

    // Assertions
    `TMAF_ASSERT_RST(a_count_range, i_clk, i_rst_n, r_count <= WINDOW_LAST,
        "window count beyond last sample")
    `TMAF_ASSERT_RST(a_empty_clear, i_clk, i_rst_n,
        r_empty |-> (r_count == '0) && (r_sum == '0),
        "empty window holds count or sum")
    `TMAF_ASSERT_RST(a_min_le_max, i_clk, i_rst_n, !r_empty |-> (r_min <= r_max),
        "window minimum above maximum")
    `TMAF_ASSERT_RST(a_result_clears, i_clk, i_rst_n,
        w_result |=> r_empty && r_out_valid,
        "window end did not clear state and raise valid")
    `TMAF_ASSERT_RST(a_rail_ignored, i_clk, i_rst_n,
        (w_accept && w_rail) |=> $stable(r_count) && $stable(r_sum),
        "rail sample changed window state")

endmodule
